/* src/gpi_pkg.sv */
package gpi_pkg;

  // Move kinds carried in the opcode field
  typedef enum logic [1:0] {
    OP_DIRECT = 2'd0,
    OP_TIMED  = 2'd1,
    OP_SPEED  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SCALE_X = 2'd0;
  localparam logic [1:0] REG_SCALE_Y = 2'd1;
  localparam logic [1:0] REG_STEP    = 2'd2;
  localparam logic [1:0] REG_SPEED   = 2'd3;

  localparam int unsigned MaxSteps = 64;
  localparam int unsigned StepW    = 7;   // holds 0..MaxSteps
  localparam logic [19:0] MicrosPerSec = 20'd1000000;

  // Dividend and quotient width of the shared serial divider.
  // Speed moves: 17-bit magnitude times 1e6 fits in 37 bits.
  localparam int unsigned DivW = 37;
  localparam int unsigned DivCntW = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,      // magnitude times 1e6, one bit a cycle
    ST_DUR_DIV,  // product / speed_limit
    ST_STEP_DIV, // duration / step_time
    ST_PT_DIV,   // |d*i| / steps per axis
    ST_SCALE,    // scale x then y, one bit a cycle each
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

/* src/gpi_div.sv */
// Restoring divider, one quotient bit per cycle.
module gpi_div
  import gpi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DivW-1:0]   dividend_i,
  input  logic [23:0]       divisor_i,
  output div_ctl_t          ctl_o,
  output logic [DivW-1:0]   quot_o,
  output logic [23:0]       rem_o
);

  logic [DivW-1:0]    quot_q, quot_d;
  logic [24:0]        rem_q, rem_d;
  logic [23:0]        dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [24:0]        trial;
  logic [25:0]        diff;

  // One shift-subtract step
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[23:0], quot_q[DivW-1]};
    diff   = {1'b0, trial} - {2'b0, dvs_q};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = DivCntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[25]) begin
        rem_d  = diff[24:0];
        quot_d = {quot_q[DivW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign ctl_o  = '{start: start_i, busy: busy_q, done: done_q};
  assign quot_o = quot_q;
  assign rem_o  = rem_q[23:0];

endmodule

/* src/galvo_point_interpolator.sv */
// Channel  | Dir | Beat contents (low bit first)
// s_axis   | in  | tuser: opcode[1:0]; tdata: target_x, target_y, duration_micros
// m_axis   | out | tdata: out_x, out_y, x_changed, y_changed, wait_micros; tlast: last
// apb      | in  | scale_x @0, scale_y @4, step_time_micros @8, speed_limit @12
//
// One move at a time. Every point is scaled bit-serially, x then y, and costs
// one load of the output register; an interpolated point adds an x and a y
// axis divide. A timed move adds a step divide, a speed move a multiply and a
// duration divide before that. Async reset clears position and last emitted
// values. A stalled output beat holds; no new input is taken until the move's
// final beat has left.
module galvo_point_interpolator
  import gpi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // target_x[15:0], target_y[31:16], duration[51:32]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // out_x, out_y, x_chg[32], y_chg[33], wait[49:34]
  output logic        m_axis_tlast,  // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic signed [15:0] scale_x_q, scale_y_q;
  logic [15:0]        step_q;
  logic [23:0]        speed_q;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= 16'sd4096;
      scale_y_q <= 16'sd4096;
      step_q    <= 16'd150;
      speed_q   <= 24'd32768;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SCALE_X: scale_x_q <= pwdata[15:0];
        REG_SCALE_Y: scale_y_q <= pwdata[15:0];
        REG_STEP:    step_q    <= pwdata[15:0];
        REG_SPEED:   speed_q   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SCALE_X: prdata = {{16{scale_x_q[15]}}, scale_x_q};
      REG_SCALE_Y: prdata = {{16{scale_y_q[15]}}, scale_y_q};
      REG_STEP:    prdata = {16'd0, step_q};
      REG_SPEED:   prdata = {8'd0, speed_q};
      default:     prdata = '0;
    endcase
  end

  // Move state
  state_e state_q, state_d;
  logic signed [15:0] pos_x_q, pos_y_q, tx_q, ty_q, emx_q, emy_q;
  logic signed [16:0] dx_q, dy_q;
  logic [DivW-1:0]    dur_q;       // full duration, speed moves exceed 20 bits
  logic [DivW-1:0]    prod_q;
  logic [16:0]        mcand_q;
  logic [19:0]        mplier_q;
  logic [StepW-1:0]   steps_q, idx_q;
  logic [15:0]        rem_q;
  logic               axis_q;      // 0 = x, 1 = y
  logic               final_q;
  logic signed [15:0] px_q, py_q;
  logic [4:0]         bcnt_q;
  logic [35:0]        acc_q;       // serial product accumulator
  logic [16:0]        sh_q;        // multiplier bits, consumed low first
  logic signed [15:0] sx_q, sy_q;
  logic               out_vld_q;
  logic [55:0]        out_data_q;
  logic               out_last_q;
  logic               in_acc, out_acc;

  assign s_axis_tready = (state_q == ST_IDLE) && !out_vld_q;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Divider operands
  logic              div_start;
  logic [DivW-1:0]   div_a;
  logic [23:0]       div_b;
  div_ctl_t          div_ctl;
  logic [DivW-1:0]   div_quot;
  logic [23:0]       div_rem;
  logic [15:0]       st_eff;
  logic [23:0]       sp_eff;
  logic [16:0]       adx, ady, amag;
  logic [16:0]       dsel;
  logic [23:0]       dmul;     // |d| * i, at most 17+7 bits
  logic              multi_pt; // step divide leaves points to interpolate

  assign st_eff = (step_q == 16'd0) ? 16'd1 : step_q;
  assign sp_eff = (speed_q == 24'd0) ? 24'd1 : speed_q;
  assign adx  = dx_q[16] ? 17'(-dx_q) : 17'(dx_q);
  assign ady  = dy_q[16] ? 17'(-dy_q) : 17'(dy_q);
  assign amag = (adx > ady) ? adx : ady;
  assign dsel = axis_q ? ady : adx;
  assign dmul = 24'(dsel) * 24'(idx_q);
  assign multi_pt = (dur_q > DivW'(st_eff)) && (div_quot != DivW'(1));

  gpi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .ctl_o      (div_ctl),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Interpolated coordinate from divider quotient
  logic signed [16:0] ofs;
  logic               neg_sel;
  logic signed [15:0] base_sel, pt;
  assign neg_sel  = axis_q ? dy_q[16] : dx_q[16];
  assign base_sel = axis_q ? pos_y_q : pos_x_q;
  assign ofs = neg_sel ? -$signed({1'b0, div_quot[15:0]}) : $signed({1'b0, div_quot[15:0]});
  assign pt  = 16'(base_sel + ofs);

  // Serial scaling operand selection
  logic signed [15:0] coord_sel, gain_sel;
  logic [35:0]        add_term;
  logic signed [35:0] sc_full, rnd;
  logic signed [23:0] q_sh;
  logic signed [15:0] sat;
  assign coord_sel = axis_q ? py_q : px_q;
  assign gain_sel  = axis_q ? scale_y_q : scale_x_q;
  // multiplicand = coord (sign-extended), multiplier = gain two's complement;
  // top multiplier bit has negative weight
  assign add_term = sh_q[0] ? (36'($signed(coord_sel)) << bcnt_q) : 36'd0;
  assign sc_full  = (bcnt_q == 5'd15) ? $signed(acc_q - add_term) : $signed(acc_q + add_term);
  assign rnd  = sc_full + 36'sd2048;
  assign q_sh = 24'(rnd >>> 12);
  assign sat  = (q_sh > 24'sd32767) ? 16'sh7FFF :
                (q_sh < -24'sd32768) ? 16'sh8000 : 16'(q_sh);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) begin
        case (op_e'(s_axis_tuser))
          OP_DIRECT: state_d = ST_SCALE;
          OP_TIMED:  state_d = ST_STEP_DIV;
          OP_SPEED:  state_d = ST_MUL;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_MUL:      if (mplier_q == 20'd0 && bcnt_q == 5'd31) state_d = ST_DUR_DIV;
      ST_DUR_DIV:  if (div_ctl.done) state_d = ST_STEP_DIV;
      ST_STEP_DIV: if (div_ctl.done) state_d = multi_pt ? ST_PT_DIV : ST_SCALE;
      ST_PT_DIV:   if (div_ctl.done) state_d = axis_q ? ST_SCALE : ST_PT_DIV;
      ST_SCALE:    if (bcnt_q == 5'd15 && axis_q) state_d = ST_EMIT;
      ST_EMIT:     if (!out_vld_q)
                     state_d = final_q ? ST_IDLE :
                               ((idx_q + 1'b1 == steps_q) ? ST_SCALE : ST_PT_DIV);
      default:     state_d = ST_IDLE;
    endcase
  end

  // Divider launch request; its registered copy drives the divider start
  logic launch_q, launch_d;
  always_comb begin
    launch_d = 1'b0;
    case (state_q)
      ST_IDLE:     launch_d = in_acc && (op_e'(s_axis_tuser) == OP_TIMED);
      ST_MUL:      launch_d = (mplier_q == 20'd0) && (bcnt_q == 5'd31);
      ST_DUR_DIV:  launch_d = div_ctl.done;
      ST_STEP_DIV: launch_d = div_ctl.done && multi_pt;
      ST_PT_DIV:   launch_d = div_ctl.done && !axis_q;
      ST_EMIT:     launch_d = !out_vld_q && !final_q && (idx_q + 1'b1 != steps_q);
      default:     launch_d = 1'b0;
    endcase
  end

  // Divider launch control
  always_comb begin
    div_start = 1'b0;
    div_a = '0;
    div_b = '0;
    case (state_q)
      ST_DUR_DIV:  begin div_a = prod_q; div_b = sp_eff; div_start = launch_q; end
      ST_STEP_DIV: begin div_a = dur_q; div_b = 24'(st_eff); div_start = launch_q; end
      ST_PT_DIV:   begin div_a = DivW'(dmul); div_b = 24'(steps_q); div_start = launch_q; end
      default: ;
    endcase
  end

  // Datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      emx_q     <= '0;
      emy_q     <= '0;
      out_vld_q <= 1'b0;
      launch_q  <= 1'b0;
      axis_q    <= 1'b0;
      final_q   <= 1'b0;
      bcnt_q    <= '0;
      idx_q     <= '0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      if (out_acc) out_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (in_acc) begin
          tx_q    <= s_axis_tdata[15:0];
          ty_q    <= s_axis_tdata[31:16];
          dur_q   <= DivW'(s_axis_tdata[51:32]);
          dx_q    <= 17'($signed(s_axis_tdata[15:0])) - 17'(pos_x_q);
          dy_q    <= 17'($signed(s_axis_tdata[31:16])) - 17'(pos_y_q);
          px_q    <= s_axis_tdata[15:0];
          py_q    <= s_axis_tdata[31:16];
          final_q <= 1'b1;
          rem_q   <= '0;
          axis_q  <= 1'b0;
          idx_q   <= StepW'(1);
          bcnt_q  <= '0;
          acc_q   <= '0;
          sh_q    <= {1'b0, scale_x_q};
          prod_q  <= '0;
          mplier_q <= MicrosPerSec;
        end
        ST_MUL: begin
          // shift-add, one multiplier bit per cycle
          if (bcnt_q == 5'd0) mcand_q <= amag;
          else begin
            if (mplier_q[0]) prod_q <= prod_q + (DivW'(mcand_q) << (bcnt_q - 1'b1));
            mplier_q <= mplier_q >> 1;
          end
          if (state_d == ST_DUR_DIV) bcnt_q <= '0;
          else if (mplier_q == 20'd0 && bcnt_q != 5'd0) bcnt_q <= 5'd31;
          else bcnt_q <= bcnt_q + 1'b1;
        end
        ST_DUR_DIV: if (div_ctl.done) begin
          dur_q <= div_quot;
        end
        ST_STEP_DIV: if (div_ctl.done) begin
          if (dur_q > DivW'(st_eff)) begin
            steps_q <= (div_quot > DivW'(MaxSteps)) ? StepW'(MaxSteps) : StepW'(div_quot);
            rem_q   <= div_rem[15:0];
            final_q <= (div_quot == DivW'(1));
          end else begin
            final_q <= 1'b1;
            rem_q   <= '0;
          end
          axis_q <= 1'b0;
          sh_q   <= {1'b0, scale_x_q};
          acc_q  <= '0;
          bcnt_q <= '0;
        end
        ST_PT_DIV: if (div_ctl.done) begin
          if (!axis_q) begin
            px_q <= pt;
            axis_q <= 1'b1;
          end else begin
            py_q <= pt;
            axis_q <= 1'b0;
            sh_q <= {1'b0, scale_x_q};
            acc_q <= '0;
            bcnt_q <= '0;
          end
        end
        ST_SCALE: begin
          if (bcnt_q == 5'd15) begin
            if (!axis_q) sx_q <= sat; else sy_q <= sat;
            axis_q <= ~axis_q;
            acc_q  <= '0;
            bcnt_q <= '0;
            sh_q   <= {1'b0, scale_y_q};
          end else begin
            acc_q  <= 36'(sc_full);
            sh_q   <= sh_q >> 1;
            bcnt_q <= bcnt_q + 1'b1;
          end
        end
        ST_EMIT: if (!out_vld_q) begin
          out_vld_q  <= 1'b1;
          out_last_q <= final_q;
          out_data_q <= {6'd0, (final_q ? rem_q : 16'd0),
                         (sy_q != emy_q), (sx_q != emx_q), sy_q, sx_q};
          emx_q <= sx_q;
          emy_q <= sy_q;
          axis_q <= 1'b0;
          sh_q   <= {1'b0, scale_x_q};
          acc_q  <= '0;
          bcnt_q <= '0;
          if (final_q) begin
            pos_x_q <= tx_q;
            pos_y_q <= ty_q;
          end else if (idx_q + 1'b1 == steps_q) begin
            idx_q   <= idx_q + 1'b1;
            final_q <= 1'b1;
            px_q    <= tx_q;
            py_q    <= ty_q;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Assertions
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped under stall");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken during a move");
  a_div_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_ctl.busy)
    else $error("divider restarted while busy");

endmodule
